### rtl/mhbe_pkg.sv
// ============================================================================
// mhbe_pkg: codes for the min-heap block
// operation codes, status codes and fixed port widths
// ============================================================================
`default_nettype none

package mhbe_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUILD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

### rtl/min_heap_build_and_extract.sv
// ============================================================================
// min_heap_build_and_extract: array-backed binary min-heap
// append, bottom-up build and delete-min over one single-port-read store
// ============================================================================
//
//   channel  | signals                                       | direction
//   ---------+-----------------------------------------------+----------
//   in       | in_valid, in_ready, func, value               | to block
//   out      | out_valid, out_ready, removed_value,          | from block
//            | root_value, element_count, status             |
//
// append and empty or unused operations go straight to the result. delete
// moves the last element into the root hole and, for each level, reads both
// children and compares, with a further step when the element settles at a
// leaf. build sifts down each inner node in the same way, from the last inner
// node down to the root. the memory read is synchronous and the two child
// reads of each level are issued one after the other.
// reset clears the count and the control state; the store needs no clearing.
// a new operation is taken while the previous result waits in the output
// register; the next result holds until that one is transferred.

`default_nettype none

module min_heap_build_and_extract #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic        [mhbe_pkg::FUNC_W-1:0]   func,
    input  wire logic signed [mhbe_pkg::VALUE_W-1:0]  value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed      [mhbe_pkg::VALUE_W-1:0]  removed_value,
    output logic signed      [mhbe_pkg::VALUE_W-1:0]  root_value,
    output logic             [mhbe_pkg::COUNT_W-1:0]  element_count,
    output logic             [mhbe_pkg::STATUS_W-1:0] status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // store address
    localparam int CW = $clog2(DEPTH + 1);                // element count
    localparam int LW = AW + 2;                           // child index
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GET    = 3'd1;  // capture sifting element
    localparam logic [2:0] S_READ_L = 3'd2;  // issue left child read
    localparam logic [2:0] S_READ_R = 3'd3;  // capture left, issue right
    localparam logic [2:0] S_CMP    = 3'd4;  // compare and move
    localparam logic [2:0] S_DONE   = 3'd5;  // hand result to output

    // heap store, synchronous read
    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] rdata_reg;
    logic                         rd_en;
    logic        [AW-1:0]         rd_addr;
    logic                         wr_en;
    logic        [AW-1:0]         wr_addr;
    logic signed [DATA_WIDTH-1:0] wr_data;

    // control and datapath registers
    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic signed [DATA_WIDTH-1:0] root_reg;     // mirror of entry zero
    logic [AW-1:0]                pos_reg, pos_next;
    logic [AW-1:0]                node_reg, node_next;
    logic                         build_reg, build_next;
    logic signed [DATA_WIDTH-1:0] v_reg, v_next;
    logic signed [DATA_WIDTH-1:0] left_reg, left_next;
    logic [mhbe_pkg::STATUS_W-1:0] status_reg, status_next;
    logic signed [DATA_WIDTH-1:0] removed_reg, removed_next;

    logic                         out_valid_reg;
    logic signed [mhbe_pkg::VALUE_W-1:0] out_removed_reg;
    logic signed [mhbe_pkg::VALUE_W-1:0] out_root_reg;
    logic [mhbe_pkg::COUNT_W-1:0] out_count_reg;
    logic [mhbe_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_load;

    // child indices of the current hole
    logic [LW-1:0]                lidx;
    logic [LW-1:0]                ridx;
    logic [LW-1:0]                count_ext;
    logic                         have_l;
    logic                         have_r;
    logic signed [DATA_WIDTH-1:0] in_word;
    logic signed [DATA_WIDTH-1:0] child_val;
    logic [AW-1:0]                child_idx;
    logic                         right_wins;

    assign in_word   = DATA_WIDTH'(value);
    assign lidx      = {1'b0, pos_reg, 1'b1};
    assign ridx      = lidx + LW'(1);
    assign count_ext = LW'(count_reg);
    assign have_l    = (lidx < count_ext);
    assign have_r    = (ridx < count_ext);

    // right child taken only when strictly smaller than the left
    assign right_wins = have_r && (rdata_reg < left_reg);
    assign child_val  = right_wins ? rdata_reg : left_reg;
    assign child_idx  = right_wins ? ridx[AW-1:0] : lidx[AW-1:0];

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        node_next    = node_reg;
        build_next   = build_reg;
        v_next       = v_reg;
        left_next    = left_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = v_reg;
        out_load     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next  = mhbe_pkg::STATUS_OK;
                    removed_next = '0;
                    state_next   = S_DONE;
                    unique case (func)
                        mhbe_pkg::FUNC_APPEND:
                        begin
                            if (count_reg >= DEPTH_C)
                            begin
                                status_next = mhbe_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = in_word;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        mhbe_pkg::FUNC_BUILD:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = mhbe_pkg::STATUS_EMPTY;
                            end
                            else if (count_reg > CW'(1))
                            begin
                                // last inner node is count/2 - 1
                                node_next  = AW'((count_reg >> 1) - CW'(1));
                                pos_next   = node_next;
                                build_next = 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = node_next;
                                state_next = S_GET;
                            end
                        end
                        mhbe_pkg::FUNC_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = mhbe_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                removed_next = root_reg;
                                count_next   = count_reg - CW'(1);
                                if (count_reg > CW'(1))
                                begin
                                    // last element fills the root hole
                                    pos_next   = '0;
                                    build_next = 1'b0;
                                    rd_en      = 1'b1;
                                    rd_addr    = count_next[AW-1:0];
                                    state_next = S_GET;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = mhbe_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                v_next     = rdata_reg;
                state_next = S_READ_L;
            end
            S_READ_L:
            begin
                if (have_l)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lidx[AW-1:0];
                    state_next = S_READ_R;
                end
                else
                begin
                    // leaf reached: element settles here
                    wr_en   = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = v_reg;
                    if (build_reg && (node_reg != '0))
                    begin
                        node_next  = node_reg - AW'(1);
                        pos_next   = node_next;
                        rd_en      = 1'b1;
                        rd_addr    = node_next;
                        state_next = S_GET;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ_R:
            begin
                left_next = rdata_reg;
                if (have_r)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ridx[AW-1:0];
                end
                state_next = S_CMP;
            end
            S_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (child_val < v_reg)
                begin
                    // smaller child moves up into the hole
                    wr_data    = child_val;
                    pos_next   = child_idx;
                    state_next = S_READ_L;
                end
                else
                begin
                    wr_data = v_reg;
                    if (build_reg && (node_reg != '0))
                    begin
                        node_next  = node_reg - AW'(1);
                        pos_next   = node_next;
                        rd_en      = 1'b1;
                        rd_addr    = node_next;
                        state_next = S_GET;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // store and its read register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            build_reg <= build_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        node_reg    <= node_next;
        v_reg       <= v_next;
        left_reg    <= left_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        if (wr_en && (wr_addr == '0))
        begin
            root_reg <= wr_data;
        end
        if (out_load)
        begin
            out_removed_reg <= mhbe_pkg::VALUE_W'(removed_reg);
            out_root_reg    <= (count_reg != '0) ? mhbe_pkg::VALUE_W'(root_reg) : '0;
            out_count_reg   <= mhbe_pkg::COUNT_W'(count_reg);
            out_status_reg  <= status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = out_removed_reg;
    assign root_value    = out_root_reg;
    assign element_count = out_count_reg;
    assign status        = out_status_reg;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: min-heap append, build and delete-min
// drives operations over the input channel, predicts each result with an
// in-bench heap model and compares every output transfer field by field
// ============================================================================

module tb;

    localparam int FUNC_W   = mhbe_pkg::FUNC_W;
    localparam int VALUE_W  = mhbe_pkg::VALUE_W;
    localparam int COUNT_W  = mhbe_pkg::COUNT_W;
    localparam int STATUS_W = mhbe_pkg::STATUS_W;

    localparam int HEAP_DEPTH   = 1024;
    localparam int HEAP_WIDTH   = 32;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 64;      // covers the tail of a deep delete
    localparam int LONG_HOLD    = 300;
    localparam int DEEP_FILL    = 100;
    localparam int RANDOM_ITEMS = 250;
    localparam int CYCLE_LIMIT  = 2000000;

    // operation code that the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [VALUE_W-1:0]  removed;
        logic signed [VALUE_W-1:0]  root;
        logic        [COUNT_W-1:0]  count;
        logic        [STATUS_W-1:0] stat;
    } heap_result_t;

    // dut ports
    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       in_ready;
    logic        [FUNC_W-1:0]   func          = mhbe_pkg::FUNC_APPEND;
    logic signed [VALUE_W-1:0]  value         = '0;
    logic                       out_valid;
    logic                       out_ready     = 1'b0;
    logic signed [VALUE_W-1:0]  removed_value;
    logic signed [VALUE_W-1:0]  root_value;
    logic        [COUNT_W-1:0]  element_count;
    logic        [STATUS_W-1:0] status;

    // heap model state, advanced once per accepted operation
    logic signed [VALUE_W-1:0]  model_heap [HEAP_DEPTH];
    int                         model_count = 0;

    // results predicted but not yet seen on the output channel
    heap_result_t               pending_results[$];

    int                         fail_count  = 0;
    int                         items_sent  = 0;
    int                         cycle_count = 0;

    // traffic shaping: bursts switch idling off on one side
    bit                         tx_burst    = 1'b0;
    bit                         rx_burst    = 1'b0;
    // a change of hold_req asks the receiver for one long hold-off
    int                         hold_req    = 0;
    int                         hold_seen   = 0;
    int                         stall_left  = 0;

    min_heap_build_and_extract #(
        .DEPTH      (HEAP_DEPTH),
        .DATA_WIDTH (HEAP_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .root_value    (root_value),
        .element_count (element_count),
        .status        (status)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // heap model
    // ------------------------------------------------------------------

    // full sift-down from one node, signed order
    function automatic void model_sift_down(input int start);
        int                        pos;
        int                        lo;
        int                        hi;
        int                        best;
        logic signed [VALUE_W-1:0] tmp;
        pos = start;
        while (pos < model_count)
        begin
            lo   = 2 * pos + 1;
            hi   = lo + 1;
            best = pos;
            if (lo < model_count && model_heap[lo] < model_heap[best])
                best = lo;
            if (hi < model_count && model_heap[hi] < model_heap[best])
                best = hi;
            if (best == pos)
                break;
            tmp              = model_heap[pos];
            model_heap[pos]  = model_heap[best];
            model_heap[best] = tmp;
            pos              = best;
        end
    endfunction

    // applies one operation to the model and returns the result it causes
    function automatic heap_result_t heap_model_apply(input logic [FUNC_W-1:0] f,
                                                      input logic signed [VALUE_W-1:0] v);
        heap_result_t r;
        int           i;
        r.removed = '0;
        r.stat    = mhbe_pkg::STATUS_OK;
        case (f)
            mhbe_pkg::FUNC_APPEND:
            begin
                // append does not restore heap order
                if (model_count >= HEAP_DEPTH)
                    r.stat = mhbe_pkg::STATUS_FULL;
                else
                begin
                    model_heap[model_count] = v;
                    model_count++;
                end
            end
            mhbe_pkg::FUNC_BUILD:
            begin
                if (model_count == 0)
                    r.stat = mhbe_pkg::STATUS_EMPTY;
                else
                    for (i = model_count / 2 - 1; i >= 0; i--)
                        model_sift_down(i);
            end
            mhbe_pkg::FUNC_DELETE:
            begin
                if (model_count == 0)
                    r.stat = mhbe_pkg::STATUS_EMPTY;
                else
                begin
                    r.removed     = model_heap[0];
                    model_heap[0] = model_heap[model_count - 1];
                    model_count--;
                    if (model_count > 0)
                        model_sift_down(0);
                end
            end
            default:
            begin
                // unused code: state untouched, status ok
            end
        endcase
        r.root  = (model_count > 0) ? model_heap[0] : '0;
        r.count = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly full-range words, some extremes and a narrow band for duplicates
    function automatic logic signed [VALUE_W-1:0] rand_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return WORD_MAX;
        if (pick < 8)
            return WORD_MIN;
        if (pick < 11)
            return '0;
        if (pick < 14)
            return -1;
        if (pick < 35)
            return $signed($urandom_range(0, 16)) - 8;
        return $urandom;
    endfunction

    // sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        if (tx_burst)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one input transfer; called at a rising edge, returns at the accepting edge
    task automatic send_op(input logic [FUNC_W-1:0] f,
                           input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(heap_model_apply(f, v));
        items_sent++;
    endtask

    // intended operation, now and then swapped for a random one
    task automatic send_mixed(input logic [FUNC_W-1:0] f,
                              input logic signed [VALUE_W-1:0] v);
        if ($urandom_range(0, 99) < 8)
            send_op(FUNC_W'($urandom_range(0, 3)), rand_word());
        else
            send_op(f, v);
    endtask

    // drop valid, wait out every predicted result and the block's tail
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random ready with short and long stalls, bursts and one
    // long hold-off on request, counted here in cycles
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : rx_drive
        int roll;
        roll = $urandom_range(0, 99);
        if (hold_req != hold_seen)
        begin
            hold_seen  <= hold_req;
            stall_left <= LONG_HOLD;
            out_ready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (rx_burst)
            out_ready <= 1'b1;
        else if (roll < 3)
        begin
            stall_left <= $urandom_range(15, 50);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= (roll < 75);
    end

    // ------------------------------------------------------------------
    // result checking against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic signed [63:0] exp_v,
                                        input logic signed [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        heap_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: root_value %0d, element_count %0d",
                       root_value, element_count);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("removed_value", exp_r.removed, removed_value);
                check_field("root_value", exp_r.root, root_value);
                check_field("element_count", exp_r.count, element_count);
                check_field("status", exp_r.stat, status);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // delete, build and the unused code on an empty heap
    task automatic test_empty_heap();
        send_op(mhbe_pkg::FUNC_DELETE, rand_word());
        send_op(mhbe_pkg::FUNC_BUILD, rand_word());
        send_op(FUNC_UNUSED, rand_word());
        wait_idle();
    endtask

    // word extremes and duplicates, delete before and after a build,
    // the deletes empty the heap and one more delete finds it empty
    task automatic test_extreme_values();
        send_op(mhbe_pkg::FUNC_APPEND, WORD_MAX);
        send_op(mhbe_pkg::FUNC_APPEND, WORD_MIN);
        send_op(mhbe_pkg::FUNC_APPEND, '0);
        send_op(mhbe_pkg::FUNC_APPEND, -1);
        send_op(mhbe_pkg::FUNC_APPEND, 1);
        send_op(mhbe_pkg::FUNC_APPEND, WORD_MAX);
        send_op(mhbe_pkg::FUNC_APPEND, WORD_MIN);
        send_op(FUNC_UNUSED, WORD_MIN);
        send_op(mhbe_pkg::FUNC_DELETE, WORD_MAX);
        send_op(mhbe_pkg::FUNC_BUILD, -1);
        while (model_count > 0)
            send_op(mhbe_pkg::FUNC_DELETE, rand_word());
        send_op(mhbe_pkg::FUNC_DELETE, '0);
        wait_idle();
    endtask

    // deep heap: fill, build over the whole heap, partial drain,
    // unordered refill, second build and drain to empty
    task automatic test_deep_heap();
        while (model_count < DEEP_FILL)
            send_op(mhbe_pkg::FUNC_APPEND, rand_word());
        send_op(FUNC_UNUSED, rand_word());
        send_op(mhbe_pkg::FUNC_BUILD, rand_word());
        repeat (24) send_op(mhbe_pkg::FUNC_DELETE, rand_word());
        repeat (20) send_op(mhbe_pkg::FUNC_APPEND, rand_word());
        send_op(mhbe_pkg::FUNC_BUILD, rand_word());
        while (model_count > 0)
            send_op(mhbe_pkg::FUNC_DELETE, rand_word());
        send_op(mhbe_pkg::FUNC_DELETE, rand_word());
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering back to back,
    // so the output register and the engine fill and in_ready drops
    task automatic test_output_backpressure();
        tx_burst = 1'b1;
        hold_req <= hold_req + 1;
        repeat (5) send_op(mhbe_pkg::FUNC_APPEND, rand_word());
        send_op(mhbe_pkg::FUNC_BUILD, rand_word());
        repeat (6) send_op(mhbe_pkg::FUNC_DELETE, rand_word());
        tx_burst = 1'b0;
        wait_idle();
    endtask

    // episodes of appends, an optional build and a run of deletes that
    // often overshoots into the empty case, with random noise operations
    task automatic test_random_traffic();
        int start_items;
        int n;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            tx_burst = ($urandom_range(0, 7) == 0);
            rx_burst <= ($urandom_range(0, 7) == 0);
            // mostly small heaps, now and then a larger one
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
            repeat (n) send_mixed(mhbe_pkg::FUNC_APPEND, rand_word());
            if ($urandom_range(0, 9) < 8)
                send_mixed(mhbe_pkg::FUNC_BUILD, rand_word());
            n = $urandom_range(0, model_count + 2);
            repeat (n) send_mixed(mhbe_pkg::FUNC_DELETE, rand_word());
        end
        tx_burst = 1'b0;
        rx_burst <= 1'b0;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial
    begin : run_tests
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_heap();
        test_extreme_values();
        test_deep_heap();
        test_output_backpressure();
        test_random_traffic();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/mhbe_pkg.sv
rtl/min_heap_build_and_extract.sv
tb/sv/tb.sv
